// ===== hdl/bmma_pkg.sv =====
// Shared constants, types and codes for the block map memory allocator.
`timescale 1ns / 1ps
package bmma_pkg;
    localparam int TABLE_DEPTH = 256;
    localparam int NUM_BANKS = 3;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int BANK_W = $clog2(NUM_BANKS);
    localparam int ADDR_W = $clog2(NUM_BANKS * TABLE_DEPTH);
    localparam int MAP_W = 9;
    localparam int BB_W = 13;
    localparam int EN_W = 9;
    localparam int SIZE_W = 20;
    localparam int PERM_W = 10;
    localparam int MUL_W = 26;
    localparam int PROD_W = 21;
    localparam int REG_IDX_W = 3;
    localparam int IN_W = 48;
    localparam int OUT_W = 40;
    localparam int BB_MAX = 4096;
    localparam int PERMILLE = 1000;
    localparam int DIV_STEPS = SIZE_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    localparam logic [REG_IDX_W-1:0] REG_BB0 = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_BB1 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_BB2 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_EN0 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_EN1 = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_EN2 = 3'd5;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_NOFIT  = 3'd1,
        ST_ZERO   = 3'd2,
        ST_NOTRDY = 3'd3,
        ST_RANGE  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        OP_INIT  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2,
        OP_USAGE = 2'd3
    } opcode_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_INIT,
        S_ALLOC_START,
        S_ALLOC_DIV,
        S_SCAN,
        S_MARK,
        S_FREE_MUL,
        S_FREE_CHK,
        S_FREE_DIV,
        S_FREE_RD,
        S_FREE_CNT,
        S_FREE_CLR,
        S_USE_SCAN,
        S_USE_MUL,
        S_USE_START,
        S_USE_DIV,
        S_RESULT
    } state_t;
endpackage

// ===== hdl/block_map_memory_allocator_unit.sv =====
// Top level of the block map memory allocator: sequencer, map memory and result register.
// Allocate runs a clear sweep first on an unready bank, then a divide, then scans the map
// with one map read per cycle and marks the run that it finds.
// Free on an unready bank only runs the clear sweep and reports not ready.
// Throughput: one transaction at a time; the map memory port and the shared divider set it.
// Reset clears all banks to not ready and the configuration registers to their defaults; no clearing pass.
`timescale 1ns / 1ps
module block_map_memory_allocator_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // opcode[1:0], bank[3:2], size_bytes[23:4], free_offset[43:24], zero pad
    input  logic [bmma_pkg::IN_W-1:0]      s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // status[2:0], alloc_offset[22:3], usage_permille[32:23], zero pad
    output logic [bmma_pkg::OUT_W-1:0]     m_tdata,
    input  logic                           cfg_we,
    input  logic [bmma_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [bmma_pkg::BB_W-1:0]      cfg_data
);
    import bmma_pkg::*;

    state_t            state_reg, state_next;
    opcode_t           op_reg, op_next;
    logic [1:0]        bank_reg, bank_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [SIZE_W-1:0] foff_reg, foff_next;
    logic [BB_W-1:0]   bb_reg, bb_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [SIZE_W-1:0] need_reg, need_next;
    logic [CNT_W-1:0]  iss_reg, iss_next;
    logic              pend_reg, pend_next;
    logic [IDX_W-1:0]  pidx_reg, pidx_next;
    logic [CNT_W-1:0]  run_reg, run_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [MAP_W-1:0]  cnt_reg, cnt_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    status_t           st_reg, st_next;
    logic [SIZE_W-1:0] aoff_reg, aoff_next;
    logic [PERM_W-1:0] perm_reg, perm_next;
    logic              ready_reg [NUM_BANKS];
    logic              ready_next [NUM_BANKS];
    logic              out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]  out_data_reg, out_data_next;
    logic [BB_W-1:0]   bb_cfg_reg [NUM_BANKS];
    logic [EN_W-1:0]   en_cfg_reg [NUM_BANKS];

    logic              bank_ok;
    logic              bank_rdy;
    logic [BANK_W-1:0] bsel;
    logic [BANK_W-1:0] in_bsel;
    logic              in_bank_ok;
    logic [BB_W-1:0]   in_bb_raw;
    logic [EN_W-1:0]   in_en_raw;
    logic [BB_W-1:0]   in_bb;
    logic [CNT_W-1:0]  in_n;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [MAP_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [MAP_W-1:0]  ram_rdata;

    logic              div_start;
    logic [SIZE_W-1:0] div_dividend;
    logic [BB_W-1:0]   div_divisor;
    logic              div_done;
    logic [SIZE_W-1:0] div_quo;
    logic [BB_W-1:0]   div_rem;

    logic [BB_W-1:0]   mul_a;
    logic [BB_W-1:0]   mul_b;
    logic [MUL_W-1:0]  mul_p;

    logic              ent_zero;
    logic [CNT_W-1:0]  run_inc;
    logic              hit;
    logic              last_eval;
    logic [IDX_W:0]    clr_pos;
    logic              clr_go;
    logic [IDX_W-1:0]  iss_idx;

    function automatic logic [ADDR_W-1:0] map_addr(input logic [BANK_W-1:0] b,
                                                   input logic [IDX_W-1:0] i);
        map_addr = ADDR_W'(b) * ADDR_W'(TABLE_DEPTH) + ADDR_W'(i);
    endfunction

    assign bsel = bank_reg[BANK_W-1:0];
    assign bank_ok = (32'(bank_reg) < NUM_BANKS);
    assign bank_rdy = bank_ok && ready_reg[bsel];

    assign in_bsel = s_tdata[2 +: BANK_W];
    assign in_bank_ok = (32'(s_tdata[3:2]) < NUM_BANKS);
    assign in_bb_raw = in_bank_ok ? bb_cfg_reg[in_bsel] : BB_W'(1);
    assign in_en_raw = in_bank_ok ? en_cfg_reg[in_bsel] : EN_W'(1);
    assign in_bb = (in_bb_raw == '0) ? BB_W'(1) :
                   ((32'(in_bb_raw) > BB_MAX) ? BB_W'(BB_MAX) : in_bb_raw);
    assign in_n = (in_en_raw == '0) ? CNT_W'(1) :
                  ((32'(in_en_raw) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH) : CNT_W'(in_en_raw));

    assign mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);

    assign ent_zero = !bank_rdy || (ram_rdata == '0);
    assign run_inc = ent_zero ? (run_reg + 1'b1) : '0;
    assign hit = pend_reg && (SIZE_W'(run_inc) == need_reg);
    assign last_eval = pend_reg && (pidx_reg == '0);
    assign clr_pos = (IDX_W + 1)'(idx_reg) + (IDX_W + 1)'(k_reg);
    assign clr_go = (MAP_W'(k_reg) < cnt_reg) && (CNT_W'(clr_pos) < n_reg);
    assign iss_idx = IDX_W'(iss_reg - 1'b1);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;

    bmma_ram #(
        .WIDTH(MAP_W),
        .DEPTH(NUM_BANKS * TABLE_DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bmma_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (!bank_ok)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    unique case (op_reg)
                        OP_INIT:  state_next = S_INIT;
                        OP_ALLOC: state_next = bank_rdy ? S_ALLOC_START : S_INIT;
                        OP_FREE:  state_next = bank_rdy ? S_FREE_MUL : S_INIT;
                        OP_USAGE: state_next = S_USE_SCAN;
                        default:  state_next = S_RESULT;
                    endcase
                end
            end
            S_INIT:
            begin
                if (k_reg == CNT_W'(TABLE_DEPTH - 1))
                begin
                    state_next = (op_reg == OP_ALLOC) ? S_ALLOC_START : S_RESULT;
                end
            end
            S_ALLOC_START: state_next = (size_reg == '0) ? S_RESULT : S_ALLOC_DIV;
            S_ALLOC_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    state_next = S_MARK;
                end
                else if (last_eval)
                begin
                    state_next = S_RESULT;
                end
            end
            S_MARK:
            begin
                if (SIZE_W'(k_reg + 1'b1) == need_reg)
                begin
                    state_next = S_RESULT;
                end
            end
            S_FREE_MUL: state_next = S_FREE_CHK;
            S_FREE_CHK:
            begin
                state_next = (PROD_W'(foff_reg) >= prod_reg) ? S_RESULT : S_FREE_DIV;
            end
            S_FREE_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_FREE_RD;
                end
            end
            S_FREE_RD:  state_next = S_FREE_CNT;
            S_FREE_CNT: state_next = S_FREE_CLR;
            S_FREE_CLR:
            begin
                if (!clr_go)
                begin
                    state_next = S_RESULT;
                end
            end
            S_USE_SCAN:
            begin
                if (last_eval)
                begin
                    state_next = S_USE_MUL;
                end
            end
            S_USE_MUL:   state_next = S_USE_START;
            S_USE_START: state_next = S_USE_DIV;
            S_USE_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        op_next = op_reg;
        bank_next = bank_reg;
        size_next = size_reg;
        foff_next = foff_reg;
        bb_next = bb_reg;
        n_next = n_reg;
        need_next = need_reg;
        iss_next = iss_reg;
        pend_next = 1'b0;
        pidx_next = pidx_reg;
        run_next = run_reg;
        k_next = k_reg;
        idx_next = idx_reg;
        cnt_next = cnt_reg;
        prod_next = prod_reg;
        st_next = st_reg;
        aoff_next = aoff_reg;
        perm_next = perm_reg;
        for (int b = 0; b < NUM_BANKS; b++)
        begin
            ready_next[b] = ready_reg[b];
        end
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next = out_data_reg;
        ram_we = 1'b0;
        ram_waddr = map_addr(bsel, idx_reg);
        ram_wdata = '0;
        ram_raddr = map_addr(bsel, idx_reg);
        div_start = 1'b0;
        div_dividend = foff_reg;
        div_divisor = bb_reg;
        mul_a = bb_reg;
        mul_b = BB_W'(n_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next = opcode_t'(s_tdata[1:0]);
                    bank_next = s_tdata[3:2];
                    size_next = s_tdata[23:4];
                    foff_next = s_tdata[43:24];
                    bb_next = in_bb;
                    n_next = in_n;
                end
            end
            S_DISPATCH:
            begin
                st_next = bank_ok ? ST_OK : ST_NOTRDY;
                aoff_next = '0;
                perm_next = '0;
                k_next = '0;
                iss_next = n_reg;
                run_next = '0;
            end
            S_INIT:
            begin
                ram_we = 1'b1;
                ram_waddr = map_addr(bsel, k_reg[IDX_W-1:0]);
                k_next = k_reg + 1'b1;
                if (k_reg == CNT_W'(TABLE_DEPTH - 1))
                begin
                    ready_next[bsel] = 1'b1;
                    if (op_reg == OP_FREE)
                    begin
                        st_next = ST_NOTRDY;
                    end
                end
            end
            S_ALLOC_START:
            begin
                if (size_reg == '0)
                begin
                    st_next = ST_ZERO;
                end
                else
                begin
                    div_start = 1'b1;
                    div_dividend = size_reg;
                end
            end
            S_ALLOC_DIV:
            begin
                need_next = div_quo + SIZE_W'(div_rem != '0);
                iss_next = n_reg;
                run_next = '0;
            end
            S_SCAN:
            begin
                ram_raddr = map_addr(bsel, iss_idx);
                if (iss_reg != '0)
                begin
                    iss_next = iss_reg - 1'b1;
                    pend_next = 1'b1;
                    pidx_next = iss_idx;
                end
                if (pend_reg)
                begin
                    run_next = run_inc;
                end
                mul_a = BB_W'(pidx_reg);
                mul_b = bb_reg;
                if (hit)
                begin
                    pend_next = 1'b0;
                    idx_next = pidx_reg;
                    k_next = '0;
                    aoff_next = mul_p[SIZE_W-1:0];
                end
                else if (last_eval)
                begin
                    st_next = ST_NOFIT;
                end
            end
            S_MARK:
            begin
                ram_we = 1'b1;
                ram_waddr = map_addr(bsel, idx_reg + k_reg[IDX_W-1:0]);
                ram_wdata = need_reg[MAP_W-1:0];
                k_next = k_reg + 1'b1;
            end
            S_FREE_MUL:
            begin
                prod_next = mul_p[PROD_W-1:0];
            end
            S_FREE_CHK:
            begin
                if (PROD_W'(foff_reg) >= prod_reg)
                begin
                    st_next = ST_RANGE;
                end
                else
                begin
                    div_start = 1'b1;
                end
            end
            S_FREE_DIV:
            begin
                idx_next = div_quo[IDX_W-1:0];
            end
            S_FREE_RD:
            begin
                k_next = '0;
            end
            S_FREE_CNT:
            begin
                cnt_next = ram_rdata;
            end
            S_FREE_CLR:
            begin
                ram_waddr = map_addr(bsel, clr_pos[IDX_W-1:0]);
                if (clr_go)
                begin
                    ram_we = 1'b1;
                    k_next = k_reg + 1'b1;
                end
            end
            S_USE_SCAN:
            begin
                ram_raddr = map_addr(bsel, iss_idx);
                if (iss_reg != '0)
                begin
                    iss_next = iss_reg - 1'b1;
                    pend_next = 1'b1;
                    pidx_next = iss_idx;
                end
                if (pend_reg && !ent_zero)
                begin
                    run_next = run_reg + 1'b1;
                end
            end
            S_USE_MUL:
            begin
                mul_a = BB_W'(run_reg);
                mul_b = BB_W'(PERMILLE);
                prod_next = mul_p[PROD_W-1:0];
            end
            S_USE_START:
            begin
                div_start = 1'b1;
                div_dividend = prod_reg[SIZE_W-1:0];
                div_divisor = BB_W'(n_reg);
            end
            S_USE_DIV:
            begin
                if (div_done)
                begin
                    perm_next = div_quo[PERM_W-1:0];
                end
            end
            S_RESULT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next = {(OUT_W - 33)'(0), perm_reg, aoff_reg, st_reg};
                end
            end
            default:
            begin
                pend_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
            pend_reg <= 1'b0;
            for (int b = 0; b < NUM_BANKS; b++)
            begin
                ready_reg[b] <= 1'b0;
                bb_cfg_reg[b] <= BB_W'(64);
                en_cfg_reg[b] <= EN_W'(TABLE_DEPTH);
            end
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            pend_reg <= pend_next;
            for (int b = 0; b < NUM_BANKS; b++)
            begin
                ready_reg[b] <= ready_next[b];
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_BB0: bb_cfg_reg[0] <= cfg_data;
                    REG_BB1: bb_cfg_reg[1] <= cfg_data;
                    REG_BB2: bb_cfg_reg[2] <= cfg_data;
                    REG_EN0: en_cfg_reg[0] <= cfg_data[EN_W-1:0];
                    REG_EN1: en_cfg_reg[1] <= cfg_data[EN_W-1:0];
                    REG_EN2: en_cfg_reg[2] <= cfg_data[EN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        bank_reg <= bank_next;
        size_reg <= size_next;
        foff_reg <= foff_next;
        bb_reg <= bb_next;
        n_reg <= n_next;
        need_reg <= need_next;
        iss_reg <= iss_next;
        pidx_reg <= pidx_next;
        run_reg <= run_next;
        k_reg <= k_next;
        idx_reg <= idx_next;
        cnt_reg <= cnt_next;
        prod_reg <= prod_next;
        st_reg <= st_next;
        aoff_reg <= aoff_next;
        perm_reg <= perm_next;
        out_data_reg <= out_data_next;
    end
endmodule

// ===== hdl/bmma_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module bmma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== hdl/bmma_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
module bmma_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [bmma_pkg::SIZE_W-1:0] dividend,
    input  logic [bmma_pkg::BB_W-1:0]   divisor,
    output logic                        done,
    output logic [bmma_pkg::SIZE_W-1:0] quotient,
    output logic [bmma_pkg::BB_W-1:0]   remainder
);
    import bmma_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [SIZE_W-1:0]    quo_reg, quo_next;
    logic [BB_W-1:0]      rem_reg, rem_next;
    logic [BB_W-1:0]      dsr_reg, dsr_next;
    logic [BB_W:0]        shifted;
    logic [BB_W:0]        diff;

    assign shifted = {rem_reg, quo_reg[SIZE_W-1]};
    assign diff = shifted - {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next = DIV_CNT_W'(DIV_STEPS);
            quo_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, dsr_reg})
            begin
                rem_next = diff[BB_W-1:0];
                quo_next = {quo_reg[SIZE_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[BB_W-1:0];
                quo_next = {quo_reg[SIZE_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done = done_reg;
    assign quotient = quo_reg;
    assign remainder = rem_reg;
endmodule

// ===== hdl/bmma_checker.sv =====
// Port-level checks for the block map memory allocator and their binding.
`timescale 1ns / 1ps
module bmma_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [bmma_pkg::OUT_W-1:0] m_tdata
);
    import bmma_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Result changed while stalled.");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("Second transaction accepted while one is in work.");

    a_offset_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[2:0] != ST_OK) |-> (m_tdata[22:3] == '0))
        else $error("Nonzero offset on a failed result.");

    a_usage_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[32:23] <= 10'(PERMILLE)) && (m_tdata[2:0] <= 3'(ST_RANGE)))
        else $error("Result field out of range.");
endmodule

bind block_map_memory_allocator_unit bmma_checker u_bmma_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
